### hw/rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and character codes for the servo command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic        valid;
    logic [7:0]  servo_number;
    logic [15:0] pulse_width;
    logic [15:0] move_time;
    logic        bad_command;
  } result_t;

endpackage

### hw/rtl/scp_in_reg.sv
// ----------------------------------------------------------------------------
// scp_in_reg
// Input register: captures one character word and holds it until parsed.
// ----------------------------------------------------------------------------
module scp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       load;

  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

### hw/rtl/scp_parse.sv
// ----------------------------------------------------------------------------
// scp_parse
// Command state machine: field accumulators, sign and digit flags, result.
// ----------------------------------------------------------------------------
module scp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           byte_data,
  output scp_pkg::result_t     result
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SERVO = 2'd1,
    PH_PULSE = 2'd2,
    PH_TIME  = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  servo_r, servo_nxt;
  logic [15:0] pulse_r, pulse_nxt;
  logic [15:0] time_r, time_nxt;
  logic        neg_r, neg_nxt;
  logic        has_digit_r, has_digit_nxt;

  logic [15:0] acc_sel;
  logic [15:0] acc_digit;
  logic [15:0] acc_fin;
  logic [7:0]  term;
  logic        is_digit;
  logic        is_minus;
  logic [7:0]  digit_off;

  assign is_digit  = (byte_data >= scp_pkg::CHAR_ZERO) && (byte_data <= scp_pkg::CHAR_NINE);
  assign is_minus  = byte_data == scp_pkg::CHAR_MINUS;
  assign digit_off = byte_data - scp_pkg::CHAR_ZERO;

  always_comb begin
    case (phase_r)
      PH_SERVO: begin
        acc_sel = {8'd0, servo_r};
        term    = scp_pkg::CHAR_P;
      end
      PH_PULSE: begin
        acc_sel = pulse_r;
        term    = scp_pkg::CHAR_T;
      end
      default: begin
        acc_sel = time_r;
        term    = scp_pkg::CHAR_CR;
      end
    endcase
  end

  assign acc_digit = (acc_sel << 3) + (acc_sel << 1) + {12'd0, digit_off[3:0]};
  assign acc_fin   = neg_r ? (16'd0 - acc_sel) : acc_sel;

  always_comb begin
    phase_nxt     = phase_r;
    servo_nxt     = servo_r;
    pulse_nxt     = pulse_r;
    time_nxt      = time_r;
    neg_nxt       = neg_r;
    has_digit_nxt = has_digit_r;
    result        = '0;
    if (fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (byte_data == scp_pkg::CHAR_HASH) begin
            phase_nxt     = PH_SERVO;
            servo_nxt     = 8'd0;
            pulse_nxt     = 16'd0;
            time_nxt      = 16'd0;
            neg_nxt       = 1'b0;
            has_digit_nxt = 1'b0;
          end
        end
        default: begin
          if (is_digit) begin
            has_digit_nxt = 1'b1;
            case (phase_r)
              PH_SERVO: servo_nxt = acc_digit[7:0];
              PH_PULSE: pulse_nxt = acc_digit;
              default:  time_nxt  = acc_digit;
            endcase
          end else if (is_minus && !has_digit_r && !neg_r) begin
            neg_nxt = 1'b1;
          end else if (is_minus || (byte_data != term) || !has_digit_r) begin
            phase_nxt          = PH_HUNT;
            neg_nxt            = 1'b0;
            has_digit_nxt      = 1'b0;
            result.valid       = 1'b1;
            result.bad_command = 1'b1;
          end else begin
            neg_nxt       = 1'b0;
            has_digit_nxt = 1'b0;
            case (phase_r)
              PH_SERVO: begin
                servo_nxt = acc_fin[7:0];
                phase_nxt = PH_PULSE;
              end
              PH_PULSE: begin
                pulse_nxt = acc_fin;
                phase_nxt = PH_TIME;
              end
              default: begin
                time_nxt            = acc_fin;
                phase_nxt           = PH_HUNT;
                result.valid        = 1'b1;
                result.servo_number = servo_r;
                result.pulse_width  = pulse_r;
                result.move_time    = acc_fin;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      servo_r     <= 8'd0;
      pulse_r     <= 16'd0;
      time_r      <= 16'd0;
      neg_r       <= 1'b0;
      has_digit_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      servo_r     <= servo_nxt;
      pulse_r     <= pulse_nxt;
      time_r      <= time_nxt;
      neg_r       <= neg_nxt;
      has_digit_r <= has_digit_nxt;
    end
  end

endmodule

### hw/rtl/scp_out_reg.sv
// ----------------------------------------------------------------------------
// scp_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module scp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  scp_pkg::result_t  result,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,
  output logic [0:0]        out_tuser
);

  logic        valid_r;
  logic        valid_nxt;
  logic [39:0] data_r;
  logic        bad_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = result.valid;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && result.valid) begin
      data_r <= {result.move_time, result.pulse_width, result.servo_number};
      bad_r  <= result.bad_command;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = bad_r;

endmodule

### hw/rtl/servo_command_parser.sv
// ----------------------------------------------------------------------------
// servo_command_parser
// Parses '#' servo 'P' pulse 'T' time CR commands from an ASCII byte stream.
// ----------------------------------------------------------------------------
// Input channel in_*: one ASCII character word per handshake. Output
// channel out_*: one result word per finished command (carriage return) or
// per malformed command, with out_tuser set for an error; the numeric
// fields are then zero. Bytes outside a command give no word.
// A character passes an input register, then the parse state machine, then
// a result register, which registers the word and raises out_tvalid when
// the state machine accepts the carriage return. One character word is
// taken every cycle while the result register is not stalled; the
// multiply-by-ten accumulate in the state machine is combinational.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to hunting for '#' with all fields cleared.
// When the receiver stalls, the result register holds its word, the parser
// stops, and in_tready falls once the input register is full.
// ----------------------------------------------------------------------------
module servo_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] servo_number, [23:8] pulse_width,
                                  // [39:24] move_time
  output logic [0:0]  out_tuser   // [0] bad_command
);

  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             out_free;
  logic             fire;
  scp_pkg::result_t result;

  assign fire = byte_valid && out_free;

  scp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (fire),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  scp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_data (byte_data),
    .result    (result)
  );

  scp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### tb/sv/tb_servo_command_parser.sv
// ----------------------------------------------------------------------------
// tb_servo_command_parser
// Self-checking bench for the servo command parser. A short table of
// directed characters covers ignored bytes, field extremes, sign handling
// and each kind of malformed command. A long stream of random commands
// follows, most of them well-formed and some corrupted, mixed with noise.
// Every accepted character steps a local parser model, and each result word
// is checked against the oldest expected move. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_servo_command_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import scp_pkg::*;

  typedef enum logic [1:0] {PH_HUNT, PH_SERVO, PH_PULSE, PH_TIME} parse_phase_t;
  typedef enum int {CORRUPT_SWAP, CORRUPT_MINUS, CORRUPT_HASH, CORRUPT_DROP} corrupt_t;

  typedef struct packed {
    logic [7:0]  servo;
    logic [15:0] pulse;
    logic [15:0] mtime;
    logic        bad;
  } servo_move_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        fixed;
    servo_move_t move;
  } char_row_t;

  localparam servo_move_t NO_MOVE  = '0;
  localparam servo_move_t BAD_MOVE = '{8'd0, 16'd0, 16'd0, 1'b1};
  localparam int          RANDOM_CHARS = 1620;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DIR_ROWS     = 29;

  localparam char_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h00,      1'b0, NO_MOVE},
    '{8'hFF,      1'b0, NO_MOVE},
    '{CHAR_HASH,  1'b0, NO_MOVE},
    '{CHAR_MINUS, 1'b0, NO_MOVE},
    '{CHAR_MINUS, 1'b1, BAD_MOVE},
    '{CHAR_HASH,  1'b0, NO_MOVE},
    '{CHAR_MINUS, 1'b0, NO_MOVE},
    '{"1",        1'b0, NO_MOVE},
    '{CHAR_P,     1'b0, NO_MOVE},
    '{CHAR_MINUS, 1'b0, NO_MOVE},
    '{"0",        1'b0, NO_MOVE},
    '{CHAR_T,     1'b0, NO_MOVE},
    '{"6",        1'b0, NO_MOVE},
    '{"5",        1'b0, NO_MOVE},
    '{"5",        1'b0, NO_MOVE},
    '{"3",        1'b0, NO_MOVE},
    '{"5",        1'b0, NO_MOVE},
    '{CHAR_CR,    1'b1, '{8'd255, 16'd0, 16'd65535, 1'b0}},
    '{CHAR_HASH,  1'b0, NO_MOVE},
    '{"1",        1'b0, NO_MOVE},
    '{CHAR_MINUS, 1'b1, BAD_MOVE},
    '{CHAR_HASH,  1'b0, NO_MOVE},
    '{CHAR_P,     1'b1, BAD_MOVE},
    '{CHAR_HASH,  1'b0, NO_MOVE},
    '{CHAR_HASH,  1'b1, BAD_MOVE},
    '{CHAR_HASH,  1'b0, NO_MOVE},
    '{"9",        1'b0, NO_MOVE},
    '{CHAR_P,     1'b0, NO_MOVE},
    '{8'hFF,      1'b1, BAD_MOVE}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;

  parse_phase_t cmd_phase;
  logic [7:0]   servo_acc;
  logic [15:0]  pulse_acc;
  logic [15:0]  time_acc;
  logic         field_neg;
  logic         field_digit;

  servo_move_t  pending_moves[$];
  logic [7:0]   char_stream[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           calm_left = 0;

  servo_command_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic parse_char(input logic [7:0] c, output logic hit, output servo_move_t mv);
    logic [15:0] acc;
    logic [15:0] mask;
    logic [7:0]  term;
    logic        err;
    logic        done;
    hit  = 1'b0;
    mv   = NO_MOVE;
    err  = 1'b0;
    done = 1'b0;
    if (cmd_phase == PH_HUNT) begin
      if (c == CHAR_HASH) begin
        cmd_phase   = PH_SERVO;
        servo_acc   = '0;
        pulse_acc   = '0;
        time_acc    = '0;
        field_neg   = 1'b0;
        field_digit = 1'b0;
      end
      return;
    end
    case (cmd_phase)
      PH_SERVO: begin
        acc  = {8'h00, servo_acc};
        mask = 16'h00FF;
        term = CHAR_P;
      end
      PH_PULSE: begin
        acc  = pulse_acc;
        mask = 16'hFFFF;
        term = CHAR_T;
      end
      default: begin
        acc  = time_acc;
        mask = 16'hFFFF;
        term = CHAR_CR;
      end
    endcase
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      acc = (acc * 16'd10 + {8'h00, c - CHAR_ZERO}) & mask;
      field_digit = 1'b1;
    end else if (c == CHAR_MINUS) begin
      if (field_digit || field_neg) err = 1'b1;
      else field_neg = 1'b1;
    end else if (c != term || !field_digit) begin
      err = 1'b1;
    end else begin
      if (field_neg) acc = (16'd0 - acc) & mask;
      field_neg   = 1'b0;
      field_digit = 1'b0;
      done        = 1'b1;
    end
    case (cmd_phase)
      PH_SERVO: servo_acc = acc[7:0];
      PH_PULSE: pulse_acc = acc;
      default:  time_acc  = acc;
    endcase
    if (err) begin
      hit         = 1'b1;
      mv          = BAD_MOVE;
      cmd_phase   = PH_HUNT;
      field_neg   = 1'b0;
      field_digit = 1'b0;
    end else if (done) begin
      case (cmd_phase)
        PH_SERVO: cmd_phase = PH_PULSE;
        PH_PULSE: cmd_phase = PH_TIME;
        default: begin
          hit       = 1'b1;
          mv        = '{servo_acc, pulse_acc, time_acc, 1'b0};
          cmd_phase = PH_HUNT;
        end
      endcase
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic fixed, input servo_move_t fixed_mv);
    int          gap;
    logic        hit;
    servo_move_t mv;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 100);
      gap = idle_len();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= c;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_char(c, hit, mv);
    if (fixed) pending_moves.push_back(fixed_mv);
    else if (hit) pending_moves.push_back(mv);
  endtask

  task automatic gen_command(ref logic [7:0] q[$]);
    logic [7:0] cmd[$];
    int         f;
    int         n;
    int         pos;
    corrupt_t   kind;
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
    end
    cmd.push_back(CHAR_HASH);
    for (f = 0; f < 3; f++) begin
      if ($urandom_range(0, 4) == 0) cmd.push_back(CHAR_MINUS);
      n = (f == 0) ? $urandom_range(1, 3) : $urandom_range(1, 6);
      repeat (n) cmd.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      cmd.push_back((f == 0) ? CHAR_P : (f == 1) ? CHAR_T : CHAR_CR);
    end
    if ($urandom_range(0, 9) < 2) begin
      pos  = $urandom_range(1, cmd.size() - 1);
      kind = corrupt_t'($urandom_range(0, 3));
      case (kind)
        CORRUPT_SWAP:  cmd[pos] = 8'($urandom_range(0, 255));
        CORRUPT_MINUS: cmd.insert(pos, CHAR_MINUS);
        CORRUPT_HASH:  cmd.insert(pos, CHAR_HASH);
        default:       cmd.delete(pos);
      endcase
    end
    foreach (cmd[i]) q.push_back(cmd[i]);
  endtask

  initial begin : ready_gen
    int run;
    int gap;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    servo_move_t got;
    servo_move_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[23:8], out_tdata[39:24], out_tuser[0]};
      if (pending_moves.size() == 0) begin
        if (mismatch_count < 100)
          $display("%0t: unexpected word servo=%0d pulse=%0d time=%0d bad=%0b",
                   $time, got.servo, got.pulse, got.mtime, got.bad);
        mismatch_count++;
      end else begin
        want = pending_moves.pop_front();
        if (got !== want) begin
          if (mismatch_count < 100)
            $display({"%0t: mismatch expected servo=%0d pulse=%0d time=%0d bad=%0b,",
                      " got servo=%0d pulse=%0d time=%0d bad=%0b"},
                     $time, want.servo, want.pulse, want.mtime, want.bad,
                     got.servo, got.pulse, got.mtime, got.bad);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    cmd_phase   = PH_HUNT;
    servo_acc   = '0;
    pulse_acc   = '0;
    time_acc    = '0;
    field_neg   = 1'b0;
    field_digit = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++)
      send_char(DIR_TABLE[i].ch, DIR_TABLE[i].fixed, DIR_TABLE[i].move);
    while (char_stream.size() < RANDOM_CHARS) gen_command(char_stream);
    foreach (char_stream[i]) send_char(char_stream[i], 1'b0, NO_MOVE);
    in_tvalid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
